FILE: rtl/bfpg_pkg.sv
`default_nettype none

package bfpg_pkg;

    // Coordinate format: signed, COORD_FRAC_BITS fraction bits, six integer bits
    localparam int COORD_FRAC_BITS = 16;
    localparam int CW              = COORD_FRAC_BITS + 6;
    localparam int COEF_W          = COORD_FRAC_BITS + 3;
    localparam int PROD_W          = CW + COEF_W;
    localparam int SUM_W           = PROD_W + 2;

    // Pixel and frame widths
    localparam int PIX_W           = 12;
    localparam int ADDR_W          = 24;
    localparam int PERIOD_W        = 16;
    localparam int DICE_W          = 7;

    // Scaling datapath widths
    localparam int SCL_W           = CW + PIX_W + 2;
    localparam int PX_W            = SCL_W - COORD_FRAC_BITS - 2;
    localparam int PY_W            = PX_W;
    localparam int N_W             = SCL_W - COORD_FRAC_BITS;
    localparam int DIV10_K         = 22;
    localparam int DIV10_M_W       = 19;
    localparam int DIV10_P_W       = N_W + DIV10_M_W;
    localparam logic [DIV10_M_W-1:0] DIV10_M = DIV10_M_W'(((64'd1 << DIV10_K) + 64'd9) / 10);

    // Front to back queue
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = $clog2(QDEPTH);

    // Configuration port
    localparam int CFG_ADDR_W      = 4;
    localparam int CFG_DATA_W      = 32;
    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_REFRESH_PERIOD = 2'd2;

    // Dice thresholds
    localparam logic [DICE_W-1:0] DICE_STEM_MAX = 7'd0;
    localparam logic [DICE_W-1:0] DICE_MAIN_MAX = 7'd85;
    localparam logic [DICE_W-1:0] DICE_LEFT_MAX = 7'd92;

    // Coefficients rounded half away from zero
    localparam longint ONE_Q = longint'(1) << COORD_FRAC_BITS;
    localparam longint K_P16  = (16 * ONE_Q + 50) / 100;
    localparam longint K_P85  = (85 * ONE_Q + 50) / 100;
    localparam longint K_P04  = (4 * ONE_Q + 50) / 100;
    localparam longint K_N04  = -((4 * ONE_Q + 50) / 100);
    localparam longint K_P160 = (160 * ONE_Q + 50) / 100;
    localparam longint K_P20  = (20 * ONE_Q + 50) / 100;
    localparam longint K_N26  = -((26 * ONE_Q + 50) / 100);
    localparam longint K_P23  = (23 * ONE_Q + 50) / 100;
    localparam longint K_P22  = (22 * ONE_Q + 50) / 100;
    localparam longint K_N15  = -((15 * ONE_Q + 50) / 100);
    localparam longint K_P28  = (28 * ONE_Q + 50) / 100;
    localparam longint K_P26  = (26 * ONE_Q + 50) / 100;
    localparam longint K_P24  = (24 * ONE_Q + 50) / 100;
    localparam longint K_P44  = (44 * ONE_Q + 50) / 100;

    typedef enum logic [1:0] {
        MAP_STEM,
        MAP_MAIN,
        MAP_LEFT,
        MAP_RIGHT
    } map_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] e;
    } coef_set_t;

    typedef struct packed {
        logic clear;
        map_t sel;
        logic refresh;
    } step_t;

    typedef struct packed {
        logic [PIX_W-1:0] width;
        logic [PIX_W-1:0] height;
    } frame_cfg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2,
        B_SUM,
        B_SCALE,
        B_DIV,
        B_ADDR
    } back_state_t;

    function automatic coef_set_t map_coefs(input map_t m);
        coef_set_t c;
        unique case (m)
            MAP_STEM:
            begin
                c = '{a: '0, b: '0, c: '0, d: COEF_W'(K_P16), e: '0};
            end
            MAP_MAIN:
            begin
                c = '{a: COEF_W'(K_P85), b: COEF_W'(K_P04), c: COEF_W'(K_N04),
                      d: COEF_W'(K_P85), e: COEF_W'(K_P160)};
            end
            MAP_LEFT:
            begin
                c = '{a: COEF_W'(K_P20), b: COEF_W'(K_N26), c: COEF_W'(K_P23),
                      d: COEF_W'(K_P22), e: COEF_W'(K_P160)};
            end
            MAP_RIGHT:
            begin
                c = '{a: COEF_W'(K_N15), b: COEF_W'(K_P28), c: COEF_W'(K_P26),
                      d: COEF_W'(K_P24), e: COEF_W'(K_P44)};
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bfpg_front.sv
`default_nettype none

module bfpg_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire logic                            cmd,
    input  wire logic [bfpg_pkg::DICE_W-1:0]     dice,
    input  wire logic [bfpg_pkg::PERIOD_W-1:0]   refresh_period,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output bfpg_pkg::step_t                      q_data
);
    import bfpg_pkg::*;

    logic [PERIOD_W-1:0] plot_count_reg;
    logic [PERIOD_W-1:0] plot_count_next;
    logic [PERIOD_W-1:0] cnt_inc;
    logic                refresh_hit;
    map_t                sel;

    assign q_push  = push && !q_full;
    assign cnt_inc = plot_count_reg + PERIOD_W'(1);

    // A zero period behaves as a full wrap of the counter
    assign refresh_hit = (refresh_period == '0) ? (cnt_inc == '0)
                                                : (cnt_inc >= refresh_period);

    always_comb
    begin
        priority if (dice <= DICE_STEM_MAX)
            sel = MAP_STEM;
        else if (dice <= DICE_MAIN_MAX)
            sel = MAP_MAIN;
        else if (dice <= DICE_LEFT_MAX)
            sel = MAP_LEFT;
        else
            sel = MAP_RIGHT;
    end

    always_comb
    begin
        plot_count_next = plot_count_reg;
        if (q_push)
        begin
            if (cmd || refresh_hit)
                plot_count_next = '0;
            else
                plot_count_next = cnt_inc;
        end
    end

    assign q_data = '{clear: cmd, sel: sel, refresh: refresh_hit && !cmd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plot_count_reg <= '0;
        else
            plot_count_reg <= plot_count_next;
    end

endmodule

`default_nettype wire

FILE: rtl/bfpg_queue.sv
`default_nettype none

module bfpg_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire bfpg_pkg::step_t wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output bfpg_pkg::step_t      rd_data,
    output logic                 not_empty
);
    import bfpg_pkg::*;

    step_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_wr;
    logic              do_rd;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    // Pointers wrap naturally: depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: rtl/bfpg_back.sv
`default_nettype none

module bfpg_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bfpg_pkg::step_t               q_data,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire bfpg_pkg::frame_cfg_t          frame,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [bfpg_pkg::PIX_W-1:0]         pixel_x,
    output logic [bfpg_pkg::PIX_W-1:0]         pixel_y,
    output logic [bfpg_pkg::ADDR_W-1:0]        pixel_address,
    output logic                               in_frame,
    output logic                               refresh,
    output logic                               clear_frame
);
    import bfpg_pkg::*;

    localparam int QW = SUM_W - COORD_FRAC_BITS;
    localparam logic signed [QW-1:0] Q_MAX = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {{(QW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (COORD_FRAC_BITS - 1);
    localparam logic signed [SCL_W-1:0] PX_BIAS =
        (SCL_W'(1) << (COORD_FRAC_BITS + 2)) - SCL_W'(1);
    localparam int PQ_W = DIV10_P_W - DIV10_K;

    // Round half up to the coordinate grid, then saturate
    function automatic logic signed [CW-1:0] narrow(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        logic signed [QW-1:0]    q;
        r = v + HALF_LSB;
        q = $signed(r[SUM_W-1:COORD_FRAC_BITS]);
        if (q > Q_MAX)
            return {1'b0, {(CW-1){1'b1}}};
        else if (q < Q_MIN)
            return {1'b1, {(CW-1){1'b0}}};
        else
            return q[CW-1:0];
    endfunction

    back_state_t state_reg;
    back_state_t state_next;

    map_t                      sel_reg;
    logic                      refresh_reg;
    logic signed [PROD_W-1:0]  pa_reg;
    logic signed [PROD_W-1:0]  pb_reg;
    logic signed [PROD_W-1:0]  pc_reg;
    logic signed [PROD_W-1:0]  pd_reg;
    logic signed [CW-1:0]      point_x_reg;
    logic signed [CW-1:0]      point_y_reg;
    logic signed [SCL_W-1:0]   pxn_reg;
    logic signed [SCL_W-1:0]   pyn_reg;
    logic signed [PX_W-1:0]    px_reg;
    logic [DIV10_P_W-1:0]      pq_prod_reg;
    logic                      py_neg_reg;

    logic                      out_valid_reg;
    logic [PIX_W-1:0]          out_x_reg;
    logic [PIX_W-1:0]          out_y_reg;
    logic [ADDR_W-1:0]         out_addr_reg;
    logic                      out_in_reg;
    logic                      out_refresh_reg;
    logic                      out_clear_reg;

    logic                      load_out;
    logic                      load_clear;
    coef_set_t                 coefs;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [SCL_W-1:0]   xw;
    logic signed [SCL_W-1:0]   yh;
    logic signed [SCL_W-1:0]   wh_term;
    logic signed [SCL_W-1:0]   h10_term;
    logic signed [SCL_W-1:0]   px_biased;
    logic [SCL_W-1:0]          py_mag;
    logic [N_W-1:0]            py_n;
    logic [PQ_W-1:0]           py_q;
    logic signed [PY_W-1:0]    py;
    logic                      in_bounds;
    logic [ADDR_W-1:0]         addr;

    assign coefs = map_coefs(sel_reg);

    // Map datapath
    assign sum_x = SUM_W'(pa_reg) + SUM_W'(pb_reg);
    assign sum_y = SUM_W'(pc_reg) + SUM_W'(pd_reg) + (SUM_W'(coefs.e) <<< COORD_FRAC_BITS);

    // Scale datapath
    assign xw       = SCL_W'(point_x_reg) * SCL_W'($signed({1'b0, frame.width}));
    assign yh       = SCL_W'(point_y_reg) * SCL_W'($signed({1'b0, frame.height}));
    assign wh_term  = $signed(SCL_W'(frame.width >> 1) << (COORD_FRAC_BITS + 2));
    assign h10_term = $signed((SCL_W'(frame.height) * SCL_W'(10)) << COORD_FRAC_BITS);

    // Truncate toward zero: bias negative numerators before the shift
    assign px_biased = pxn_reg + (pxn_reg[SCL_W-1] ? PX_BIAS : SCL_W'(0));
    assign py_mag    = pyn_reg[SCL_W-1] ? SCL_W'(-pyn_reg) : SCL_W'(pyn_reg);
    assign py_n      = py_mag[SCL_W-1:COORD_FRAC_BITS];

    assign py_q = pq_prod_reg[DIV10_P_W-1:DIV10_K];
    assign py   = py_neg_reg ? -$signed({1'b0, py_q}) : $signed({1'b0, py_q});

    assign in_bounds = !px_reg[PX_W-1]
                    && (px_reg < $signed({{(PX_W-PIX_W){1'b0}}, frame.width}))
                    && !py[PY_W-1]
                    && (py < $signed({{(PY_W-PIX_W){1'b0}}, frame.height}));
    assign addr = ADDR_W'(py[PIX_W-1:0]) * ADDR_W'(frame.width) + ADDR_W'(px_reg[PIX_W-1:0]);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        load_clear = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.clear)
                    begin
                        // A restart passes straight to the output once it is free
                        if (!out_valid_reg)
                        begin
                            q_pop      = 1'b1;
                            load_out   = 1'b1;
                            load_clear = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        state_next = B_MUL1;
                    end
                end
            end
            B_MUL1:  state_next = B_MUL2;
            B_MUL2:  state_next = B_SUM;
            B_SUM:   state_next = B_SCALE;
            B_SCALE: state_next = B_DIV;
            B_DIV:   state_next = B_ADDR;
            B_ADDR:
            begin
                if (!out_valid_reg)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            point_x_reg   <= '0;
            point_y_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_SUM)
            begin
                point_x_reg <= narrow(sum_x);
                point_y_reg <= narrow(sum_y);
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_data.clear)
        begin
            sel_reg     <= q_data.sel;
            refresh_reg <= q_data.refresh;
        end
        if (state_reg == B_MUL1)
        begin
            pa_reg <= PROD_W'(coefs.a) * PROD_W'(point_x_reg);
            pb_reg <= PROD_W'(coefs.b) * PROD_W'(point_y_reg);
        end
        if (state_reg == B_MUL2)
        begin
            pc_reg <= PROD_W'(coefs.c) * PROD_W'(point_x_reg);
            pd_reg <= PROD_W'(coefs.d) * PROD_W'(point_y_reg);
        end
        if (state_reg == B_SCALE)
        begin
            pxn_reg <= xw + wh_term;
            pyn_reg <= h10_term - yh;
        end
        if (state_reg == B_DIV)
        begin
            px_reg      <= px_biased[SCL_W-1:COORD_FRAC_BITS+2];
            pq_prod_reg <= DIV10_P_W'(py_n) * DIV10_P_W'(DIV10_M);
            py_neg_reg  <= pyn_reg[SCL_W-1];
        end
        if (load_out)
        begin
            if (load_clear)
            begin
                out_x_reg       <= '0;
                out_y_reg       <= '0;
                out_addr_reg    <= '0;
                out_in_reg      <= 1'b0;
                out_refresh_reg <= 1'b0;
                out_clear_reg   <= 1'b1;
            end
            else
            begin
                out_x_reg       <= in_bounds ? px_reg[PIX_W-1:0] : '0;
                out_y_reg       <= in_bounds ? py[PIX_W-1:0] : '0;
                out_addr_reg    <= in_bounds ? addr : '0;
                out_in_reg      <= in_bounds;
                out_refresh_reg <= refresh_reg;
                out_clear_reg   <= 1'b0;
            end
        end
    end

    assign empty         = !out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign pixel_address = out_addr_reg;
    assign in_frame      = out_in_reg;
    assign refresh       = out_refresh_reg;
    assign clear_frame   = out_clear_reg;

endmodule

`default_nettype wire

FILE: rtl/barnsley_fern_point_generator.sv
// A plot word passes the front and the queue, then the back end steps B_MUL1, B_MUL2, B_SUM, B_SCALE, B_DIV, B_ADDR.
// The back end takes one plot word at a time: its sequencer walks one shared map/scale datapath
// through multiply, sum, scale, divide and address steps, and waits there while the output is full.
// Restart words skip the map/scale steps and go from the queue to the output once it is free.
// Reset (rst_n, asynchronous, active low): point at the origin, plot count zero, queue empty,
// registers back to 640 x 480 with a refresh period of 10000.
`default_nettype none

module barnsley_fern_point_generator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Step words in
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                cmd,
    input  wire logic [bfpg_pkg::DICE_W-1:0]         dice,
    // Result words out
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [bfpg_pkg::PIX_W-1:0]               pixel_x,
    output logic [bfpg_pkg::PIX_W-1:0]               pixel_y,
    output logic [bfpg_pkg::ADDR_W-1:0]              pixel_address,
    output logic                                     in_frame,
    output logic                                     refresh,
    output logic                                     clear_frame,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bfpg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [bfpg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bfpg_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import bfpg_pkg::*;

    // Configuration registers
    logic [PIX_W-1:0]    frame_width_reg;
    logic [PIX_W-1:0]    frame_height_reg;
    logic [PERIOD_W-1:0] refresh_period_reg;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    // Front to back hand-off
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    step_t      q_wr_data;
    step_t      q_rd_data;
    frame_cfg_t frame;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write on the access cycle; addresses beyond the list drop the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= PIX_W'(640);
            frame_height_reg   <= PIX_W'(480);
            refresh_period_reg <= PERIOD_W'(10000);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:    frame_width_reg    <= pwdata[PIX_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= pwdata[PIX_W-1:0];
                REG_REFRESH_PERIOD: refresh_period_reg <= pwdata[PERIOD_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back the addressed register, zero beyond the list
    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:    prdata = CFG_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:   prdata = CFG_DATA_W'(frame_height_reg);
            REG_REFRESH_PERIOD: prdata = CFG_DATA_W'(refresh_period_reg);
            default:            prdata = '0;
        endcase
    end

    assign frame = '{width: frame_width_reg, height: frame_height_reg};
    assign full  = q_full;

    // Front: accept words, pick the map, advance the plot count and flag refreshes
    bfpg_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .cmd            (cmd),
        .dice           (dice),
        .refresh_period (refresh_period_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wr_data)
    );

    // Two-entry queue lets the front keep taking words while the back iterates
    bfpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_rd_data),
        .not_empty (q_valid)
    );

    // Back: apply the affine map, scale to the frame, hold the result word
    bfpg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_rd_data),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .frame         (frame),
        .pop           (pop),
        .empty         (empty),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .in_frame      (in_frame),
        .refresh       (refresh),
        .clear_frame   (clear_frame)
    );

endmodule

`default_nettype wire

FILE: rtl/bfpg_checker.sv
`default_nettype none

module bfpg_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                empty,
    input wire logic                                pop,
    input wire logic [bfpg_pkg::PIX_W-1:0]          pixel_x,
    input wire logic [bfpg_pkg::PIX_W-1:0]          pixel_y,
    input wire logic [bfpg_pkg::ADDR_W-1:0]         pixel_address,
    input wire logic                                in_frame,
    input wire logic                                refresh,
    input wire logic                                clear_frame
);
    import bfpg_pkg::*;

    // A waiting result word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_x) && $stable(pixel_y)
                              && $stable(pixel_address) && $stable(clear_frame)))
        else $error("result word changed while waiting");

    // Single output register: the result side is empty in the cycle after a word is taken
    a_one_deep: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
        else $error("new result word appeared right after a pop");

    // A clear-frame word carries no pixel and no refresh
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && clear_frame) |-> (pixel_x == '0 && pixel_y == '0
                                     && pixel_address == '0 && !in_frame && !refresh))
        else $error("clear-frame word carries pixel data");

    // An out-of-frame plot reports pixel zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !in_frame) |-> (pixel_x == '0 && pixel_y == '0 && pixel_address == '0))
        else $error("out-of-frame word carries pixel data");

endmodule

bind barnsley_fern_point_generator bfpg_checker u_bfpg_checker (.*);

`default_nettype wire
